// ===== rtl/core/min_square_sum_count_macros.svh =====
// Assertion macros for the min_square_sum_count checker.
// No dependencies; clock and reset are taken by name from the including scope.
`ifndef MIN_SQUARE_SUM_COUNT_MACROS_SVH
`define MIN_SQUARE_SUM_COUNT_MACROS_SVH

// check a property on every clock edge outside reset
`define MSQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("min_square_sum_count assertion failed");

// check a property on every clock edge, reset included
`define MSQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("min_square_sum_count reset assertion failed");

`endif

// ===== rtl/core/msq_pkg.sv =====
// Shared constants and types for the min_square_sum_count block.
// No dependencies.
package msq_pkg;

  localparam int TARGET_W  = 12;
  localparam int RESULT_W  = 3;
  localparam int DEF_MAX_N = 4096;

  typedef logic [TARGET_W-1:0] target_t;
  typedef logic [RESULT_W-1:0] count_t;

  // upper bound on any count (four-square theorem)
  localparam count_t BOUND = count_t'(4);

endpackage

// ===== rtl/core/msq_table.sv =====
// Scratch table of square counts: one write port, one registered read port.
// Depends on msq_pkg.
module msq_table #(
  parameter int MAX_N = msq_pkg::DEF_MAX_N,
  localparam int AW = $clog2(MAX_N)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  msq_pkg::count_t wdata,
  input  logic [AW-1:0]   raddr,
  output msq_pkg::count_t rdata
);
  import msq_pkg::*;

  count_t mem [MAX_N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/msq_seq.sv =====
// Sequencer and shared min/compare unit that fills the square count table.
// Depends on msq_pkg; drives the ports of msq_table.
module msq_seq #(
  parameter int MAX_N = msq_pkg::DEF_MAX_N,
  localparam int AW = $clog2(MAX_N)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  msq_pkg::target_t target_value,
  output logic             done,
  output msq_pkg::count_t  min_squares,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output msq_pkg::count_t  mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  msq_pkg::count_t  mem_rdata
);
  import msq_pkg::*;

  localparam int SW = AW + 1;
  localparam logic [31:0] LAST = 32'(MAX_N - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] n;
  logic [AW-1:0] i;
  logic [SW-1:0] sq;
  logic [SW-1:0] odd;
  count_t        best;
  logic          pend;

  logic [AW-1:0] n_in;
  count_t        cand;
  count_t        best_min;
  logic          in_range;
  logic          last_i;

  assign n_in     = (32'(target_value) > LAST) ? AW'(LAST) : AW'(target_value);
  assign cand     = count_t'(mem_rdata + 1'b1);
  // pend marks that mem_rdata holds the entry read in the previous cycle
  assign best_min = (pend && (cand < best)) ? cand : best;
  assign in_range = (sq <= {1'b0, i});
  assign last_i   = (i == n);
  assign busy     = (state != ST_IDLE);

  assign mem_raddr = i - sq[AW-1:0];
  assign mem_waddr = i;
  assign mem_we    = (state == ST_FILL) || ((state == ST_SCAN) && !in_range);
  assign mem_wdata = (state == ST_FILL) ? count_t'(i[1:0]) : best_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n     <= n_in;
            i     <= '0;
            state <= ST_FILL;
          end
        end
        ST_FILL: begin
          // entries 0..3 hold their own index
          if (last_i) begin
            done        <= 1'b1;
            min_squares <= count_t'(i[1:0]);
            state       <= ST_IDLE;
          end else if (i[1:0] == 2'd3) begin
            i     <= i + 1'b1;
            best  <= BOUND;
            sq    <= SW'(1);
            odd   <= SW'(3);
            pend  <= 1'b0;
            state <= ST_SCAN;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_SCAN: begin
          if (in_range) begin
            best <= best_min;
            sq   <= sq + odd;
            odd  <= odd + SW'(2);
            pend <= 1'b1;
          end else begin
            // entry i is final and written this cycle
            pend <= 1'b0;
            if (last_i) begin
              done        <= 1'b1;
              min_squares <= best_min;
              state       <= ST_IDLE;
            end else begin
              i    <= i + 1'b1;
              best <= BOUND;
              sq   <= SW'(1);
              odd  <= SW'(3);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/min_square_sum_count.sv =====
// min_square_sum_count: least number of perfect squares that sum to a target.
// Channels: an item (target_value) is taken on a clock edge with start high and
// busy low. busy stays high while the table is built; done pulses for one cycle
// with min_squares valid in the first cycle that busy is low again. The receiver
// cannot stall, so each result is shown once and must be captured on that cycle.
// Targets at or above MAX_N saturate to MAX_N - 1.
// Sequencing: the table is filled bottom-up from entry 0 to entry n. Entries 0..3
// are written directly; every later entry i steps through its square candidates
// one at a time through the single table read port and the shared min compare,
// then commits the entry. A new item can be taken in the done cycle; while busy
// is high no new item is taken.
// Reset returns the sequencer to idle and clears done; the table itself is
// not cleared, as every entry is rewritten before it is read.
// Depends on msq_pkg, msq_seq, msq_table.
module min_square_sum_count #(
  parameter int MAX_N = msq_pkg::DEF_MAX_N
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  msq_pkg::target_t target_value,
  output logic             done,
  output msq_pkg::count_t  min_squares
);
  import msq_pkg::*;

  localparam int AW = $clog2(MAX_N);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  count_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  count_t        mem_rdata;

  msq_seq #(.MAX_N(MAX_N)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .target_value (target_value),
    .done         (done),
    .min_squares  (min_squares),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  msq_table #(.MAX_N(MAX_N)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/core/msq_checker.sv =====
// Port-level checks for min_square_sum_count, attached to it by bind.
// Depends on msq_pkg and min_square_sum_count_macros.svh.
`include "min_square_sum_count_macros.svh"

module msq_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input msq_pkg::target_t target_value,
  input logic             done,
  input msq_pkg::count_t  min_squares
);
  import msq_pkg::*;

  `MSQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done)
  `MSQ_ASSERT(a_accept_busy, start && !busy |=> busy)
  `MSQ_ASSERT(a_done_after_busy, done |-> !busy && $past(busy))
  `MSQ_ASSERT(a_count_bound, done |-> min_squares <= BOUND)
  `MSQ_ASSERT(a_zero_target, start && !busy && target_value == '0 |=> ##1 done && min_squares == '0)

endmodule

bind min_square_sum_count msq_checker u_msq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .target_value (target_value),
  .done         (done),
  .min_squares  (min_squares)
);

// ===== sim/tb_min_square_sum_count.sv =====
// Testbench for min_square_sum_count: directed targets, then mostly small random targets.
// Each result is checked against a typed-in answer or a dynamic-programming count of squares kept here.
// Depends on msq_pkg and the min_square_sum_count RTL.
module tb_min_square_sum_count;
  import msq_pkg::*;

  localparam int MAX_N        = DEF_MAX_N;
  localparam int N_DIRECTED   = 20;
  localparam int N_RANDOM     = 100;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    target_t target;
    logic    known;    // answer typed in below, otherwise predicted
    count_t  answer;
  } directed_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  target_t target_value;
  logic    done;
  count_t  min_squares;

  count_t square_counts [MAX_N];
  count_t pending_counts [$];
  int     failures = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{12'd0,    1'b1, 3'd0},
    '{12'd1,    1'b1, 3'd1},
    '{12'd2,    1'b1, 3'd2},
    '{12'd3,    1'b1, 3'd3},
    '{12'd4,    1'b1, 3'd1},
    '{12'd7,    1'b1, 3'd4},
    '{12'd5,    1'b0, 3'd0},
    '{12'd6,    1'b0, 3'd0},
    '{12'd8,    1'b0, 3'd0},
    '{12'd12,   1'b0, 3'd0},
    '{12'd13,   1'b0, 3'd0},
    '{12'd15,   1'b1, 3'd4},
    '{12'd16,   1'b1, 3'd1},
    '{12'd48,   1'b0, 3'd0},
    '{12'd60,   1'b0, 3'd0},
    '{12'd1023, 1'b1, 3'd4},
    '{12'd1024, 1'b1, 3'd1},
    '{12'd1365, 1'b0, 3'd0},
    '{12'd2048, 1'b0, 3'd0},
    '{12'd4095, 1'b1, 3'd4}
  };

  min_square_sum_count u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .target_value (target_value),
    .done         (done),
    .min_squares  (min_squares)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("Some tests failed");
    $finish;
  end

  // bottom-up fill of the square-count table, entries 0..n
  function automatic count_t min_square_terms(int unsigned target);
    int unsigned n;
    int unsigned best;
    int unsigned cand;
    n = target;
    if (n >= MAX_N) n = MAX_N - 1;
    for (int unsigned i = 0; i <= n; i++) begin
      if (i < BOUND) begin
        square_counts[i] = count_t'(i);
      end else begin
        best = BOUND;
        for (int unsigned x = 1; x * x <= i; x++) begin
          cand = 1 + square_counts[i - x * x];
          if (cand < best) best = cand;
        end
        square_counts[i] = count_t'(best);
      end
    end
    return square_counts[n];
  endfunction

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // large targets take longest to run, so most picks stay small
  function automatic target_t pick_target();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return target_t'($urandom_range(0, 4095));
    if (sel < 15) return target_t'($urandom_range(256, 1023));
    return target_t'($urandom_range(0, 255));
  endfunction

  task automatic send_target(target_t n, count_t answer);
    @(negedge clk);
    start        <= 1'b1;
    target_value <= n;
    do @(posedge clk); while (busy);
    pending_counts.push_back(answer);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start        <= 1'b0;
      target_value <= target_t'($urandom);
      repeat (cycles - 1) begin
        @(negedge clk);
        target_value <= target_t'($urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        $error("min_squares: no result expected, got %0d", min_squares);
        failures++;
      end else begin
        if (min_squares !== pending_counts[0]) begin
          $error("min_squares: expected %0d, got %0d", pending_counts[0], min_squares);
          failures++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  initial begin
    target_t n;
    count_t  answer;
    bit      burst;
    rst          = 1'b1;
    start        = 1'b0;
    target_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      n = directed_rows[r].target;
      answer = directed_rows[r].known ? directed_rows[r].answer : min_square_terms(n);
      send_target(n, answer);
      idle_for(pick_gap(1'b0));
    end

    burst = 1'b0;
    for (int k = 0; k < N_RANDOM; k++) begin
      // alternate stretches of back-to-back items with idled ones
      if (k % 10 == 0) burst = ($urandom_range(0, 3) == 0);
      n = pick_target();
      send_target(n, min_square_terms(n));
      idle_for(pick_gap(burst));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/msq_pkg.sv
rtl/core/msq_table.sv
rtl/core/msq_seq.sv
rtl/core/min_square_sum_count.sv
rtl/core/msq_checker.sv
sim/tb_min_square_sum_count.sv
